// ----- rtl/core/gbm_pkg.sv -----
// shared types, constants and helper functions of the gaussian blur block
package gbm_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_RADIUS = 3;
    localparam int DEF_CHANNELS   = 3;

    localparam int DIM_W      = 14;
    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COEF_W     = 16;
    localparam int HS_W       = 27;
    localparam int ACC_W      = 46;
    localparam int PROD_W     = 62;
    localparam int NUM_CH     = 3;

    localparam logic [1:0]        RST_RADIUS = 2'd1;
    localparam logic [63:0]       RST_COEFFS = 64'd1177187249;
    localparam logic [15:0]       RST_GAIN   = 16'd256;
    localparam logic [15:0]       RST_OFFSET = 16'd0;
    localparam logic [12:0]       RST_WIDTH  = 13'd640;
    localparam logic [12:0]       RST_HEIGHT = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 3'd0,
        CFG_COEFFS = 3'd1,
        CFG_GAIN   = 3'd2,
        CFG_OFFSET = 3'd3,
        CFG_WIDTH  = 3'd4,
        CFG_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_SLOT,
        S_RD,
        S_MAC,
        S_VMAC,
        S_GAIN
    } t_state;

    typedef struct packed {
        logic [1:0]       radius;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_geom;

    typedef struct packed {
        logic                          valid;
        logic                          last;
        logic [NUM_CH-1:0][ACC_W-1:0]  acc;
    } t_fin_req;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic [NUM_CH-1:0][7:0]   px;
    } t_fin_rsp;

    // reflect about the first and last index without repeating the edge
    function automatic logic [DIM_W-1:0] mirror(input logic signed [DIM_W+1:0] v,
                                                input logic [DIM_W-1:0] n);
        logic signed [DIM_W+1:0] t;
        logic signed [DIM_W+1:0] nm1;
        nm1 = $signed({2'b00, n}) - 16'sd1;
        t   = (v < 0) ? -v : v;
        if (t > nm1) t = (nm1 <<< 1) - t;
        if (t < 0) t = '0;
        if (t > nm1) t = nm1;
        return t[DIM_W-1:0];
    endfunction

    function automatic logic [COEF_W-1:0] weight(input logic [63:0] coeffs,
                                                 input logic [2:0] a);
        logic [COEF_W-1:0] w;
        case (a)
            3'd0:    w = coeffs[15:0];
            3'd1:    w = coeffs[31:16];
            3'd2:    w = coeffs[47:32];
            3'd3:    w = coeffs[63:48];
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/gbm_if.sv -----
// stream interfaces for pixel beats in and filtered pixel beats out
interface gbm_pix_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] pixel_c0;
    logic [7:0] pixel_c1;
    logic [7:0] pixel_c2;

    modport source (output valid, output kind, output pixel_c0, output pixel_c1,
                    output pixel_c2, input ready);
    modport sink (input valid, input kind, input pixel_c0, input pixel_c1,
                  input pixel_c2, output ready);
endinterface

interface gbm_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_c0;
    logic [7:0] out_c1;
    logic [7:0] out_c2;
    logic       last_pixel;

    modport source (output valid, output out_c0, output out_c1, output out_c2,
                    output last_pixel, input ready);
    modport sink (input valid, input out_c0, input out_c1, input out_c2,
                  input last_pixel, output ready);
endinterface

// ----- rtl/core/gbm_line_store.sv -----
// line store ring: one write port, one registered read port
module gbm_line_store #(
    parameter int MAX_WIDTH  = gbm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = gbm_pkg::DEF_MAX_RADIUS,
    localparam int SLOTS = 2 * MAX_RADIUS + 2,
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int SW    = $clog2(SLOTS),
    localparam int AW    = SW + CW
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [gbm_pkg::PIX_W-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [gbm_pkg::PIX_W-1:0] o_rdata
);
    import gbm_pkg::*;

    localparam int DEPTH = SLOTS << CW;

    logic [PIX_W-1:0] r_mem [0:DEPTH-1];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/gbm_engine.sv -----
// frame counters and tap sequencer: writes the line store, walks the window
module gbm_engine #(
    parameter int MAX_WIDTH  = gbm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = gbm_pkg::DEF_MAX_RADIUS,
    localparam int SLOTS = 2 * MAX_RADIUS + 2,
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int SW    = $clog2(SLOTS),
    localparam int AW    = SW + CW
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gbm_pkg::t_geom            i_geom,
    input  logic [63:0]               i_coeffs,
    input  logic                      i_restart,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_kind,
    input  logic [gbm_pkg::PIX_W-1:0] i_pix,
    input  logic                      i_out_free,
    output gbm_pkg::t_fin_req         o_fin,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic [gbm_pkg::PIX_W-1:0] o_wdata,
    output logic                      o_re,
    output logic [AW-1:0]             o_raddr,
    input  logic [gbm_pkg::PIX_W-1:0] i_rdata
);
    import gbm_pkg::*;

    t_state r_state, n_state;

    logic [CW-1:0]    r_in_col, n_in_col;
    logic [DIM_W-1:0] r_in_row, n_in_row;
    logic [SW-1:0]    r_in_slot, n_in_slot;
    logic [25:0]      r_pos, n_pos;
    logic [CW-1:0]    r_out_col, n_out_col;
    logic [DIM_W-1:0] r_out_row, n_out_row;
    logic signed [3:0] r_dy, n_dy;
    logic signed [3:0] r_dx, n_dx;
    logic [DIM_W-1:0] r_row, n_row;
    logic [SW-1:0]    r_slot, n_slot;
    logic [NUM_CH-1:0][HS_W-1:0]  r_hs, n_hs;
    logic [NUM_CH-1:0][ACC_W-1:0] r_acc, n_acc;

    logic             accept;
    logic             in_frame;
    logic             no_out;
    logic [25:0]      lag;
    logic             in_col_end;
    logic             out_col_end;
    logic             last;
    logic signed [3:0] rad;
    logic [3:0]       ring_m1;
    logic [2:0]       adx, ady;
    logic [COEF_W-1:0] wdx, wdy;
    logic signed [DIM_W+1:0] vrow, vcol;
    logic [DIM_W-1:0] col_m;
    logic [11:0]      half;
    logic [27:0]      q_prod;
    logic [11:0]      q3;
    logic [1:0]       m3;
    logic [2:0]       slot3;
    logic [DIM_W-1:0] wm1, hm1;

    assign rad     = $signed({2'b00, i_geom.radius});
    assign ring_m1 = {1'b0, i_geom.radius, 1'b1};
    assign wm1     = i_geom.width - 1'b1;
    assign hm1     = i_geom.height - 1'b1;

    // stream position of the first beat that releases a result: r*w + r
    assign lag = (i_geom.radius[1] ? {11'd0, i_geom.width, 1'b0} : 26'd0) +
                 (i_geom.radius[0] ? {12'd0, i_geom.width} : 26'd0) +
                 26'(i_geom.radius);

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign in_frame    = r_in_row < i_geom.height;
    assign no_out      = r_pos < lag;
    assign in_col_end  = DIM_W'(r_in_col) == wm1;
    assign out_col_end = DIM_W'(r_out_col) == wm1;
    assign last        = (r_out_row == hm1) && out_col_end;

    assign adx = (r_dx < 0) ? 3'(-r_dx) : 3'(r_dx);
    assign ady = (r_dy < 0) ? 3'(-r_dy) : 3'(r_dy);
    assign wdx = weight(i_coeffs, adx);
    assign wdy = weight(i_coeffs, ady);

    assign vrow  = $signed({2'b00, r_out_row}) + (DIM_W+2)'(r_dy);
    assign vcol  = $signed({{(DIM_W+2-CW){1'b0}}, r_out_col}) + (DIM_W+2)'(r_dx);
    assign col_m = mirror(vcol, i_geom.width);

    // row modulo ring; ring of six goes through a reciprocal of three
    assign half   = r_row[12:1];
    assign q_prod = 28'(half) * 28'h000AAAB;
    assign q3     = q_prod[27:16] >> 1;
    assign m3     = 2'(half - 12'(q3 * 12'd3));

    always_comb begin
        case (i_geom.radius)
            2'd0:    slot3 = {2'b00, r_row[0]};
            2'd1:    slot3 = {1'b0, r_row[1:0]};
            2'd2:    slot3 = {m3, r_row[0]};
            default: slot3 = r_row[2:0];
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !no_out) n_state = S_ROW;
            end
            S_ROW:  n_state = S_SLOT;
            S_SLOT: n_state = S_RD;
            S_RD:   n_state = S_MAC;
            S_MAC: begin
                n_state = (r_dx == rad) ? S_VMAC : S_RD;
            end
            S_VMAC: begin
                n_state = (r_dy == rad) ? S_GAIN : S_ROW;
            end
            S_GAIN: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_we       = 1'b0;
        o_re       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_we       = accept && in_frame;
            end
            S_RD:   o_re = 1'b1;
            default: ;
        endcase
    end

    assign o_waddr    = {r_in_slot, r_in_col};
    assign o_wdata    = i_kind ? '0 : i_pix;
    assign o_raddr    = {r_slot, col_m[CW-1:0]};
    assign o_fin.valid = (r_state == S_GAIN) && i_out_free;
    assign o_fin.last = last;
    assign o_fin.acc  = r_acc;

    // datapath and counters
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_slot = r_in_slot;
        n_pos     = r_pos;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_dy      = r_dy;
        n_dx      = r_dx;
        n_row     = r_row;
        n_slot    = r_slot;
        n_hs      = r_hs;
        n_acc     = r_acc;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_col_end) begin
                        n_in_col = '0;
                        n_in_row = r_in_row + 1'b1;
                        n_in_slot = (4'(r_in_slot) == ring_m1) ? '0 : r_in_slot + 1'b1;
                    end else begin
                        n_in_col = r_in_col + 1'b1;
                    end
                    n_pos = r_pos + 1'b1;
                    n_dy  = -rad;
                    n_acc = '0;
                end else if (i_restart) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_in_slot = '0;
                    n_pos     = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end
            end
            S_ROW: n_row = mirror(vrow, i_geom.height);
            S_SLOT: begin
                n_slot = SW'(slot3);
                n_dx   = -rad;
                n_hs   = '0;
            end
            S_MAC: begin
                for (int c = 0; c < NUM_CH; c++) begin
                    n_hs[c] = r_hs[c] + HS_W'(wdx) * HS_W'(i_rdata[8*c +: 8]);
                end
                n_dx = r_dx + 1'b1;
            end
            S_VMAC: begin
                for (int c = 0; c < NUM_CH; c++) begin
                    n_acc[c] = r_acc[c] + ACC_W'(wdy) * ACC_W'(r_hs[c]);
                end
                n_dy = r_dy + 1'b1;
            end
            S_GAIN: begin
                if (i_out_free) begin
                    if (last) begin
                        n_in_col  = '0;
                        n_in_row  = '0;
                        n_in_slot = '0;
                        n_pos     = '0;
                        n_out_col = '0;
                        n_out_row = '0;
                    end else if (out_col_end) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + 1'b1;
                    end else begin
                        n_out_col = r_out_col + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_slot <= '0;
            r_pos     <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_state   <= n_state;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_in_slot <= n_in_slot;
            r_pos     <= n_pos;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dy   <= n_dy;
        r_dx   <= n_dx;
        r_row  <= n_row;
        r_slot <= n_slot;
        r_hs   <= n_hs;
        r_acc  <= n_acc;
    end

endmodule

// ----- rtl/core/gbm_finish.sv -----
// gain, offset, round and clamp of the window sums, two register stages
module gbm_finish #(
    parameter int CHANNELS = gbm_pkg::DEF_CHANNELS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_gain,
    input  logic signed [15:0] i_offset,
    input  gbm_pkg::t_fin_req  i_req,
    output gbm_pkg::t_fin_rsp  o_rsp
);
    import gbm_pkg::*;

    localparam logic signed [63:0] SAT_LIM = 64'sd255 <<< 40;
    localparam logic signed [63:0] HALF    = 64'sd1 <<< 39;

    logic                          r_v1, r_v2;
    logic                          r_last1, r_last2;
    logic [NUM_CH-1:0][PROD_W-1:0] r_prod;
    logic [NUM_CH-1:0][7:0]        r_px, n_px;
    logic signed [63:0]            off_al;

    assign off_al = 64'(i_offset) <<< 32;

    always_comb begin
        logic signed [63:0] v;
        logic signed [63:0] rv;
        for (int c = 0; c < NUM_CH; c++) begin
            v  = $signed({2'b00, r_prod[c]}) + off_al;
            rv = v + HALF;
            if (c >= CHANNELS || v < 0) begin
                n_px[c] = 8'd0;
            end else if (v >= SAT_LIM) begin
                n_px[c] = 8'd255;
            end else begin
                n_px[c] = rv[47:40];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last1 <= i_req.last;
        r_last2 <= r_last1;
        for (int c = 0; c < NUM_CH; c++) begin
            r_prod[c] <= PROD_W'(i_req.acc[c]) * PROD_W'(i_gain);
        end
        r_px <= n_px;
    end

    assign o_rsp.valid = r_v2;
    assign o_rsp.last  = r_last2;
    assign o_rsp.px    = r_px;

endmodule

// ----- rtl/core/gaussian_blur_mirror_border.sv -----
// top level of the mirror-border gaussian blur: config, line store, sequencer, output
//
//  channel   dir   beat contents
//  i_in      in    kind, pixel_c0, pixel_c1, pixel_c2
//  o_out     out   out_c0, out_c1, out_c2, last_pixel
//  i_cfg_*   in    register index, write data (no handshake)
//
//  a beat that yields no result leaves the sequencer idle and ready for the
//  next beat; one that yields a result is worked through the single read port
//  of the line store one tap at a time, one window row at a time
//  sync active-low reset clears counters and control; line store is not cleared
//  a finished pixel waits in the output register while the next beat enters
//  radius, width or height writes restart the frame if the sequencer is idle with no beat accepted
module gaussian_blur_mirror_border #(
    parameter int MAX_WIDTH  = gbm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = gbm_pkg::DEF_MAX_RADIUS,
    parameter int CHANNELS   = gbm_pkg::DEF_CHANNELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gbm_pix_in_if.sink                    i_in,
    gbm_pix_out_if.source                 o_out,
    input  logic                          i_cfg_we,
    input  logic [gbm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gbm_pkg::*;

    localparam int SLOTS = 2 * MAX_RADIUS + 2;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SW    = $clog2(SLOTS);
    localparam int AW    = SW + CW;

    logic [1:0]        r_radius;
    logic [63:0]       r_coeffs;
    logic [15:0]       r_gain;
    logic signed [15:0] r_offset;
    logic [12:0]       r_width;
    logic [12:0]       r_height;

    logic              r_out_valid;
    logic [NUM_CH-1:0][7:0] r_out_px;
    logic              r_out_last;

    t_geom             geom;
    t_fin_req          fin_req;
    t_fin_rsp          fin_rsp;
    logic              restart;
    logic              out_free;
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [PIX_W-1:0]  wdata, rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RST_RADIUS;
            r_coeffs <= RST_COEFFS;
            r_gain   <= RST_GAIN;
            r_offset <= RST_OFFSET;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIUS: r_radius <= i_cfg_data[1:0];
                CFG_COEFFS: r_coeffs <= i_cfg_data;
                CFG_GAIN:   r_gain   <= i_cfg_data[15:0];
                CFG_OFFSET: r_offset <= i_cfg_data[15:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[12:0];
                CFG_HEIGHT: r_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign restart = i_cfg_we && ((i_cfg_idx == CFG_RADIUS) || (i_cfg_idx == CFG_WIDTH) ||
                                  (i_cfg_idx == CFG_HEIGHT));

    // effective geometry
    always_comb begin
        if (32'(r_radius) > MAX_RADIUS) geom.radius = 2'(MAX_RADIUS);
        else                            geom.radius = r_radius;
        if (r_width == '0)                   geom.width = DIM_W'(1);
        else if (32'(r_width) > MAX_WIDTH)   geom.width = DIM_W'(MAX_WIDTH);
        else                                 geom.width = DIM_W'(r_width);
        geom.height = (r_height == '0) ? DIM_W'(1) : DIM_W'(r_height);
    end

    assign out_free = !r_out_valid || o_out.ready;

    gbm_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_RADIUS(MAX_RADIUS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    gbm_engine #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_RADIUS(MAX_RADIUS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_coeffs  (r_coeffs),
        .i_restart (restart),
        .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready),
        .i_kind    (i_in.kind),
        .i_pix     ({i_in.pixel_c2, i_in.pixel_c1, i_in.pixel_c0}),
        .i_out_free(out_free),
        .o_fin     (fin_req),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_re      (re),
        .o_raddr   (raddr),
        .i_rdata   (rdata)
    );

    gbm_finish #(
        .CHANNELS(CHANNELS)
    ) u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gain  (r_gain),
        .i_offset(r_offset),
        .i_req   (fin_req),
        .o_rsp   (fin_rsp)
    );

    // output register; the sequencer only hands a pixel to the finish stages when this slot is free or being emptied
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_rsp.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_rsp.valid) begin
            r_out_px   <= fin_rsp.px;
            r_out_last <= fin_rsp.last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_c0     = r_out_px[0];
    assign o_out.out_c1     = r_out_px[1];
    assign o_out.out_c2     = r_out_px[2];
    assign o_out.last_pixel = r_out_last;

endmodule

// ----- rtl/core/gbm_checker.sv -----
// port-level checks of the blur block and their bind
module gbm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_c0,
    input logic [7:0] i_out_c1,
    input logic [7:0] i_out_c2,
    input logic       i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_c0) && $stable(i_out_c1) && $stable(i_out_c2) &&
            $stable(i_out_last))
        else $error("stalled output beat changed");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind gaussian_blur_mirror_border gbm_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_c0   (o_out.out_c0),
    .i_out_c1   (o_out.out_c1),
    .i_out_c2   (o_out.out_c2),
    .i_out_last (o_out.last_pixel)
);

// ----- sim/gaussian_blur_mirror_border_tb.sv -----
// self-checking testbench of the mirror-border gaussian blur with its own blur predictor
module gaussian_blur_mirror_border_tb;
    import gbm_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] c2;
        logic [7:0] c1;
        logic [7:0] c0;
    } t_pix_beat;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       last;
    } t_blurred;

    localparam int LINE_LEN   = 4096;
    localparam int LINE_SLOTS = 8;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gbm_pix_in_if  pix_in ();
    gbm_pix_out_if pix_out ();

    gaussian_blur_mirror_border i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (pix_in),
        .o_out      (pix_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor copy of the registers and the frame position
    logic [1:0]         blur_radius;
    logic [63:0]        blur_coeffs;
    logic [15:0]        blur_gain;
    logic signed [15:0] blur_offset;
    logic [12:0]        blur_width;
    logic [12:0]        blur_height;
    logic [23:0]        line_store [0:LINE_SLOTS*LINE_LEN-1];
    int in_col, in_row, out_col, out_row;

    t_pix_beat beat_q[$];
    t_blurred  blurred_q[$];
    int        errors;
    bit        no_idle;
    int        in_gap;
    int        out_stall;
    t_pix_beat cur_beat;

    always #2 i_clk = ~i_clk;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic int eff_width();
        if (blur_width < 1) return 1;
        if (blur_width > LINE_LEN) return LINE_LEN;
        return blur_width;
    endfunction

    function automatic int eff_height();
        return (blur_height < 1) ? 1 : blur_height;
    endfunction

    function automatic int reflect(input int v, input int n);
        if (v < 0) v = -v;
        if (v > n - 1) v = 2 * (n - 1) - v;
        if (v < 0) v = 0;
        if (v > n - 1) v = n - 1;
        return v;
    endfunction

    function automatic longint unsigned tap_weight(input int d);
        int a;
        a = (d < 0) ? -d : d;
        if (a > 3) return 0;
        return blur_coeffs[16*a +: 16];
    endfunction

    function automatic logic [7:0] scale_round(input longint unsigned acc);
        longint v;
        v = longint'(acc * {48'd0, blur_gain}) + (longint'(blur_offset) <<< 32);
        if (v < 0) return 8'd0;
        if (v >= (64'sd255 <<< 40)) return 8'd255;
        return 8'((v + (64'sd1 <<< 39)) >>> 40);
    endfunction

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // works out the blurred pixel that an accepted beat releases, if any
    function automatic void blur_pixel(input t_pix_beat b);
        int w, h, r, ring, row, col;
        longint pos, lag;
        longint unsigned acc, hs;
        logic [7:0] ch [3];
        t_blurred res;
        w = eff_width();
        h = eff_height();
        r = blur_radius;
        ring = 2 * r + 2;
        pos = longint'(in_row) * w + in_col;
        lag = longint'(r) * w + r;
        if (pos < longint'(w) * h)
            line_store[(in_row % ring) * LINE_LEN + in_col] = b.kind ? 24'd0 : {b.c2, b.c1, b.c0};
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (pos < lag) return;
        for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int dy = -r; dy <= r; dy++) begin
                row = reflect(out_row + dy, h);
                hs = 0;
                for (int dx = -r; dx <= r; dx++) begin
                    col = reflect(out_col + dx, w);
                    hs += tap_weight(dx) * line_store[(row % ring) * LINE_LEN + col][8*c +: 8];
                end
                acc += tap_weight(dy) * hs;
            end
            ch[c] = scale_round(acc);
        end
        res.c0 = ch[0];
        res.c1 = ch[1];
        res.c2 = ch[2];
        res.last = (out_row == h - 1) && (out_col == w - 1);
        blurred_q.push_back(res);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (res.last) restart_frame();
    endfunction

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (pix_in.valid && pix_in.ready) blur_pixel(cur_beat);
            if (!pix_in.valid || pix_in.ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    pix_in.valid <= 1'b0;
                end else if (beat_q.size() > 0) begin
                    cur_beat = beat_q.pop_front();
                    pix_in.kind     <= cur_beat.kind;
                    pix_in.pixel_c0 <= cur_beat.c0;
                    pix_in.pixel_c1 <= cur_beat.c1;
                    pix_in.pixel_c2 <= cur_beat.c2;
                    pix_in.valid    <= 1'b1;
                    in_gap <= no_idle ? 0 : $urandom_range(0, 17);
                end else begin
                    pix_in.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        int st;
        t_blurred e;
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
            out_stall <= 0;
        end else begin
            st = out_stall;
            if (pix_out.valid && pix_out.ready) begin
                if (blurred_q.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    e = blurred_q.pop_front();
                    if (pix_out.out_c0 !== e.c0)
                        report($sformatf("out_c0 %0d, expected %0d", pix_out.out_c0, e.c0));
                    if (pix_out.out_c1 !== e.c1)
                        report($sformatf("out_c1 %0d, expected %0d", pix_out.out_c1, e.c1));
                    if (pix_out.out_c2 !== e.c2)
                        report($sformatf("out_c2 %0d, expected %0d", pix_out.out_c2, e.c2));
                    if (pix_out.last_pixel !== e.last)
                        report($sformatf("last_pixel %0b, expected %0b",
                                         pix_out.last_pixel, e.last));
                end
                st = no_idle ? 0 : $urandom_range(0, 17);
            end
            if (st > 0) begin
                pix_out.ready <= 1'b0;
                out_stall <= st - 1;
            end else begin
                pix_out.ready <= 1'b1;
                out_stall <= 0;
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_RADIUS: begin blur_radius = data[1:0]; restart_frame(); end
            CFG_COEFFS: blur_coeffs = data;
            CFG_GAIN:   blur_gain = data[15:0];
            CFG_OFFSET: blur_offset = data[15:0];
            CFG_WIDTH:  begin blur_width = data[12:0]; restart_frame(); end
            CFG_HEIGHT: begin blur_height = data[12:0]; restart_frame(); end
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (beat_q.size() != 0 || pix_in.valid || blurred_q.size() != 0);
        // a beat with no result may still be in flight
        repeat (150) @(posedge i_clk);
    endtask

    // style: 0 random, 1 extremes, 2 all zero, 3 all full
    task automatic run_frame(input int r, input logic [63:0] coeffs, input logic [15:0] g,
                             input logic [15:0] off, input int w, input int h,
                             input int style, input bit cut, inout int count);
        int total, frame_px;
        t_pix_beat b;
        wait_idle();
        write_reg(CFG_RADIUS, 64'(r));
        write_reg(CFG_COEFFS, coeffs);
        write_reg(CFG_GAIN, 64'(g));
        write_reg(CFG_OFFSET, 64'(off));
        write_reg(CFG_WIDTH, 64'(w));
        write_reg(CFG_HEIGHT, 64'(h));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        frame_px = eff_width() * eff_height();
        total = frame_px + r * eff_width() + r;
        // frames broken off early stay short
        if (cut) total = $urandom_range(1, (total < 300) ? total : 300);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < total; i++) begin
            b = 25'($urandom);
            case (style)
                1: b[23:0] = (i % 2) ? 24'hffffff : 24'h000000;
                2: b[23:0] = 24'h000000;
                3: b[23:0] = 24'hffffff;
                default: ;
            endcase
            // mostly pixels inside the frame, mostly flush slots in the drain tail
            if (i < frame_px) b.kind = ($urandom_range(0, 9) == 0);
            else b.kind = ($urandom_range(0, 4) != 0);
            beat_q.push_back(b);
        end
        count += total;
    endtask

    function automatic logic [63:0] pick_coeffs();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return 64'hffff_ffff_ffff_ffff;
            default: return {16'($urandom_range(0, 2000)), 16'($urandom_range(0, 9000)),
                             16'($urandom_range(0, 20000)), 16'($urandom_range(0, 40000))};
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hffff;
            2, 3: return 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2, 3: return 16'd0;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int n;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_RADIUS;
        i_cfg_data = '0;
        pix_in.valid = 1'b0;
        pix_in.kind = 1'b0;
        pix_in.pixel_c0 = 8'd0;
        pix_in.pixel_c1 = 8'd0;
        pix_in.pixel_c2 = 8'd0;
        pix_out.ready = 1'b0;
        errors = 0;
        no_idle = 1'b0;
        n = 0;
        blur_radius = RST_RADIUS;
        blur_coeffs = RST_COEFFS;
        blur_gain = RST_GAIN;
        blur_offset = RST_OFFSET;
        blur_width = RST_WIDTH;
        blur_height = RST_HEIGHT;
        restart_frame();
        for (int i = 0; i < LINE_SLOTS * LINE_LEN; i++) line_store[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, flush inside the frame, pixels in the drain tail, tiny frames
        run_frame(1, RST_COEFFS, 16'd256, 16'd0, 4, 3, 1, 0, n);
        run_frame(0, 64'h0000_0000_0000_ffff, 16'd256, 16'd0, 1, 1, 3, 0, n);
        run_frame(3, 64'hffff_ffff_ffff_ffff, 16'hffff, 16'h7fff, 2, 2, 1, 0, n);
        run_frame(2, RST_COEFFS, 16'd0, 16'h8000, 0, 0, 3, 0, n);
        run_frame(3, 64'h0400_1000_2000_4000, 16'd256, 16'h0080, 3, 1, 0, 0, n);

        // random frames, a few broken off early
        while (n < 650)
            run_frame($urandom_range(0, 3), pick_coeffs(), pick_gain(), pick_offset(),
                      $urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 9) == 0,
                      $urandom_range(0, 7) == 0, n);

        // oversized width register broken off early, then a tall narrow frame
        run_frame(0, pick_coeffs(), pick_gain(), pick_offset(), 8191, 1, 0, 1, n);
        run_frame(1, RST_COEFFS, 16'd256, 16'd0, 1, 200, 0, 0, n);

        wait_idle();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
